### rtl/core/mofb_pkg.sv
// Shared constants and types of the monochrome OLED frame store and refresh unit.
package mofb_pkg;

  localparam int unsigned PANEL_COLUMNS_DEF = 128;
  localparam int unsigned PANEL_ROWS_DEF    = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // Page-mode update stream: three command slots, then one slot per column.
  localparam int unsigned CMD_SLOTS         = 3;
  localparam int unsigned SLOT_PAGE_CMD     = 0;
  localparam int unsigned SLOT_COL_LOW_CMD  = 1;

  localparam logic [7:0] CTRL_COMMAND  = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h02;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_REFRESH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_CLEAR,
    OP_REFRESH
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WRITE,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] x_pos;
    logic [6:0] y_pos;
    logic       pixel_on;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/mofb_if.sv
// Valid/ready channel interfaces for draw/refresh items and refresh bytes.
interface mofb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] x_pos;
  logic [6:0] y_pos;
  logic       pixel_on;

  modport source (output valid, kind, x_pos, y_pos, pixel_on, input ready);
  modport sink   (input valid, kind, x_pos, y_pos, pixel_on, output ready);
endinterface

interface mofb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] control_byte;
  logic [7:0] payload_byte;
  logic       frame_end;

  modport source (output valid, control_byte, payload_byte, frame_end, input ready);
  modport sink   (input valid, control_byte, payload_byte, frame_end, output ready);
endinterface

### rtl/core/mofb_front.sv
// Front end: takes input beats, drops off-panel draws and unused kinds, queues the rest.
module mofb_front import mofb_pkg::*; #(
  parameter int unsigned PANEL_COLUMNS = PANEL_COLUMNS_DEF,
  parameter int unsigned PANEL_ROWS    = PANEL_ROWS_DEF
) (
  mofb_in_if.sink  in_i,
  input  logic     hold_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  localparam int unsigned PAGE_COUNT = PANEL_ROWS / 8;

  logic keep;
  logic on_panel;

  assign on_panel = ({1'b0, in_i.x_pos} < 9'(PANEL_COLUMNS))
                 && ({1'b0, in_i.y_pos} < 8'(PANEL_ROWS))
                 && ({1'b0, in_i.y_pos[6:3]} < 5'(PAGE_COUNT));

  always_comb begin
    keep               = 1'b0;
    q_entry_o.op       = OP_REFRESH;
    q_entry_o.x_pos    = in_i.x_pos;
    q_entry_o.y_pos    = in_i.y_pos;
    q_entry_o.pixel_on = in_i.pixel_on;
    unique case (kind_e'(in_i.kind))
      KIND_DRAW: begin
        keep         = on_panel;
        q_entry_o.op = OP_DRAW;
      end
      KIND_CLEAR: begin
        keep         = 1'b1;
        q_entry_o.op = OP_CLEAR;
      end
      KIND_REFRESH: begin
        keep         = 1'b1;
        q_entry_o.op = OP_REFRESH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Hold off new beats while the queue is full or the store is being swept.
  assign in_i.ready = !q_full_i && !hold_i;
  assign q_push_o   = in_i.valid && in_i.ready && keep;

endmodule

### rtl/core/mofb_queue.sv
// Short FIFO of classified operations between the front end and the back end.
module mofb_queue import mofb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  entry_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  q_entry_t          ent_q [DEPTH];
  logic [PTRW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = ent_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNTW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

### rtl/core/mofb_back.sv
// Back end: frame store memory, pixel read-modify-write, clear sweep and refresh stream.
module mofb_back import mofb_pkg::*; #(
  parameter int unsigned PANEL_COLUMNS = PANEL_COLUMNS_DEF,
  parameter int unsigned PANEL_ROWS    = PANEL_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  q_entry_t    q_entry_i,
  output logic        q_pop_o,
  output logic        sweeping_o,
  mofb_out_if.source  out_o
);

  localparam int unsigned PAGE_COUNT  = PANEL_ROWS / 8;
  localparam int unsigned STORE_BYTES = PANEL_COLUMNS * PAGE_COUNT;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned SLOT_COUNT  = CMD_SLOTS + PANEL_COLUMNS;
  localparam int unsigned SW          = $clog2(SLOT_COUNT);
  localparam int unsigned XW          = AW + 9;

  back_state_e state_q, state_d;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic [AW-1:0] sweep_q, sweep_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [PW-1:0] page_q, page_d;
  logic [AW-1:0] draw_addr_q, draw_addr_d;
  logic [2:0]    bit_q, bit_d;
  logic          on_q, on_d;
  logic          end_q, end_d;

  logic          out_valid_q;
  logic [7:0]    ctrl_q, pay_q;
  logic          fend_q;
  logic          out_load;
  logic [7:0]    ctrl_ld, pay_ld;
  logic          fend_ld;
  logic          out_free;

  logic [XW-1:0] draw_addr_w, data_addr_w;
  logic [SW-1:0] col;
  logic          data_slot, slot_last, sweep_last;
  logic [7:0]    bit_mask;

  assign draw_addr_w = XW'(q_entry_i.x_pos)
                     + XW'(q_entry_i.y_pos[6:3]) * XW'(PANEL_COLUMNS);
  assign col         = slot_q - SW'(CMD_SLOTS);
  assign data_addr_w = XW'(page_q) * XW'(PANEL_COLUMNS) + XW'(col);
  assign data_slot   = (slot_q >= SW'(CMD_SLOTS));
  assign slot_last   = (slot_q == SW'(SLOT_COUNT - 1));
  assign sweep_last  = (sweep_q == AW'(STORE_BYTES - 1));
  assign bit_mask    = 8'b1 << bit_q;
  assign out_free    = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.op)
            OP_DRAW:    state_d = ST_WRITE;
            OP_CLEAR:   state_d = ST_SWEEP;
            OP_REFRESH: begin
              if (out_free && data_slot) state_d = ST_EMIT;
            end
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = sweep_q;
    mem_wdata   = 8'h00;
    mem_re      = 1'b0;
    mem_raddr   = AW'(draw_addr_w);
    sweep_d     = sweep_q;
    slot_d      = slot_q;
    page_d      = page_q;
    draw_addr_d = draw_addr_q;
    bit_d       = bit_q;
    on_d        = on_q;
    end_d       = end_q;
    out_load    = 1'b0;
    ctrl_ld     = CTRL_COMMAND;
    pay_ld      = 8'h00;
    fend_ld     = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        mem_we  = 1'b1;
        sweep_d = sweep_last ? '0 : sweep_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.op)
            OP_DRAW: begin
              q_pop_o     = 1'b1;
              mem_re      = 1'b1;
              draw_addr_d = AW'(draw_addr_w);
              bit_d       = q_entry_i.y_pos[2:0];
              on_d        = q_entry_i.pixel_on;
            end
            OP_CLEAR: begin
              q_pop_o = 1'b1;
              sweep_d = '0;
            end
            OP_REFRESH: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                if (slot_last) begin
                  slot_d = '0;
                  page_d = (page_q == '0) ? PW'(PAGE_COUNT - 1) : page_q - 1'b1;
                end else begin
                  slot_d = slot_q + 1'b1;
                end
                if (data_slot) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(data_addr_w);
                  end_d     = (page_q == '0) && slot_last;
                end else begin
                  out_load = 1'b1;
                  priority if (slot_q == SW'(SLOT_PAGE_CMD)) begin
                    pay_ld = CMD_PAGE_BASE + 8'(page_q);
                  end else if (slot_q == SW'(SLOT_COL_LOW_CMD)) begin
                    pay_ld = CMD_COL_LOW;
                  end else begin
                    pay_ld = CMD_COL_HIGH;
                  end
                end
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = draw_addr_q;
        mem_wdata = on_q ? (rd_data_q | bit_mask) : (rd_data_q & ~bit_mask);
      end
      ST_EMIT: begin
        out_load = 1'b1;
        ctrl_ld  = CTRL_DATA;
        pay_ld   = rd_data_q;
        fend_ld  = end_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      slot_q      <= '0;
      page_q      <= PW'(PAGE_COUNT - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      slot_q      <= slot_d;
      page_q      <= page_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    draw_addr_q <= draw_addr_d;
    bit_q       <= bit_d;
    on_q        <= on_d;
    end_q       <= end_d;
    if (out_load) begin
      ctrl_q <= ctrl_ld;
      pay_q  <= pay_ld;
      fend_q <= fend_ld;
    end
  end

  assign sweeping_o         = (state_q == ST_SWEEP);
  assign out_o.valid        = out_valid_q;
  assign out_o.control_byte = ctrl_q;
  assign out_o.payload_byte = pay_q;
  assign out_o.frame_end    = fend_q;

endmodule

### rtl/core/mono_oled_framebuffer_refresh_unit.sv
// Top level: OLED frame store with pixel draw, clear and page-mode refresh stream.
// Draw: the back end reads the memory byte, then writes the modified byte.
// Refresh: command bytes go straight to the output register; data bytes first pass the registered store read.
// Clear: one store byte per cycle over all PANEL_COLUMNS*PANEL_ROWS/8 bytes (1024 by default).
// Reset runs the same clearing pass; input ready stays low until it finishes.
// A 2-entry queue and the output register let either side stall independently.
module mono_oled_framebuffer_refresh_unit import mofb_pkg::*; #(
  parameter int unsigned PANEL_COLUMNS = PANEL_COLUMNS_DEF,
  parameter int unsigned PANEL_ROWS    = PANEL_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mofb_in_if.sink    in_i,
  mofb_out_if.source out_o
);

  logic      q_push;
  logic      q_pop;
  q_entry_t  q_entry_in;
  q_entry_t  q_head;
  q_status_t q_status;
  logic      sweeping;

  mofb_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_front (
    .in_i      (in_i),
    .hold_i    (sweeping),
    .q_full_i  (q_status.full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry_in)
  );

  mofb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_entry_in),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  mofb_back #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!q_status.empty),
    .q_entry_i  (q_head),
    .q_pop_o    (q_pop),
    .sweeping_o (sweeping),
    .out_o      (out_o)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweeping |-> !in_i.ready)
    else $error("input beat accepted during clearing pass");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_frame_end_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_end) |-> (out_o.control_byte == CTRL_DATA))
    else $error("frame end flagged on a command byte");

endmodule
